@@ rtl/fcgss_pkg.sv @@
package fcgss_pkg;

   // Sizing of the sequencer
   localparam int CHANNEL_COUNT = 4;
   localparam int MAX_STEPS     = 32;
   localparam int TEMPO_REFRESH = 512;

   localparam int STEP_W    = $clog2(MAX_STEPS);
   localparam int LEN_W     = $clog2(MAX_STEPS + 1);
   localparam int REFRESH_W = (TEMPO_REFRESH > 1) ? $clog2(TEMPO_REFRESH) : 1;
   localparam int LEVEL_W   = 12;
   localparam int TICK_W    = 13;
   localparam int HOLD_W    = 16;
   localparam int LED_W     = 5;

   localparam int GATE_SHIFT   = 12;
   localparam int LENGTH_SHIFT = 7;

   // Register map
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_HOLD = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEMPO_OFFSET = 4'd1;

   localparam logic [HOLD_W-1:0] HOLD_RESET   = 16'd4000;
   localparam logic [TICK_W-1:0] OFFSET_RESET = 13'd4224;

   typedef struct packed {
      logic               clear_pressed;
      logic [3:0]         record_buttons;
      logic [LEVEL_W-1:0] tempo_level;
      logic [LEVEL_W-1:0] length_level;
      logic [LEVEL_W-1:0] gate_length_0;
      logic [LEVEL_W-1:0] gate_length_1;
      logic [LEVEL_W-1:0] gate_length_2;
      logic [LEVEL_W-1:0] gate_length_3;
   } req_type;

   typedef struct packed {
      logic [3:0]       gate_outputs;
      logic [LED_W-1:0] step_leds;
      logic [4:0]       current_step;
      logic             showing_length;
   } rsp_type;

   // What the tick stage hands to the gate lanes
   typedef struct packed {
      logic [CHANNEL_COUNT-1:0]              pattern_bits;
      logic [CHANNEL_COUNT-1:0][LEVEL_W-1:0] gate_level;
      logic [TICK_W-1:0]                     delay;
      logic [TICK_W-1:0]                     tick;
      logic [LED_W-1:0]                      step_leds;
      logic [4:0]                            current_step;
      logic                                  showing_length;
   } stage_type;

endpackage

@@ rtl/fcgss_tick_ctrl.sv @@
module fcgss_tick_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [fcgss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fcgss_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                            csr_ready,
   input  logic                            accept,
   input  fcgss_pkg::req_type              req_payload,
   output fcgss_pkg::stage_type            stage_out
);
   import fcgss_pkg::*;

   logic [HOLD_W-1:0]        hold_ticks_ff;
   logic [TICK_W-1:0]        tempo_offset_ff;
   logic [CHANNEL_COUNT-1:0] pattern_ff [MAX_STEPS];
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [TICK_W-1:0]        tick_ff, tick_in;
   logic [TICK_W-1:0]        delay_ff, delay_in;
   logic [REFRESH_W-1:0]     refresh_ff, refresh_in;
   logic [LEN_W-1:0]         last_len_ff;
   logic [HOLD_W-1:0]        countdown_ff, countdown_in;
   logic                     primed_ff;
   stage_type                stage_ff, stage_in;

   logic [LEN_W-1:0]         steps;
   logic [LEN_W-1:0]         step_plus;
   logic [HOLD_W-1:0]        countdown_mid;
   logic [CHANNEL_COUNT-1:0] row_old, row_new;
   logic [LED_W-1:0]         shown;

   assign csr_ready = 1'b1;
   assign stage_out = stage_ff;

   // Take register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff   <= HOLD_RESET;
         tempo_offset_ff <= OFFSET_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_DISPLAY_HOLD) begin
            hold_ticks_ff <= csr_wdata[HOLD_W-1:0];
         end else if (csr_index == CSR_TEMPO_OFFSET) begin
            tempo_offset_ff <= csr_wdata[TICK_W-1:0];
         end
      end
   end

   // Work out the tick: delay latch, record, advance and display
   always_comb begin
      steps = LEN_W'(req_payload.length_level >> LENGTH_SHIFT) + LEN_W'(1);
      if (steps > LEN_W'(MAX_STEPS)) begin
         steps = LEN_W'(MAX_STEPS);
      end

      delay_in = delay_ff;
      if (refresh_ff == '0) begin
         if (tempo_offset_ff >= TICK_W'(req_payload.tempo_level)) begin
            delay_in = tempo_offset_ff - TICK_W'(req_payload.tempo_level);
         end else begin
            delay_in = '0;
         end
      end
      if (refresh_ff == REFRESH_W'(TEMPO_REFRESH - 1)) begin
         refresh_in = '0;
      end else begin
         refresh_in = refresh_ff + REFRESH_W'(1);
      end

      row_old = pattern_ff[step_ff];
      row_new = row_old;
      for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
         if (req_payload.record_buttons[ch]) begin
            row_new[ch] = !req_payload.clear_pressed;
         end
      end

      countdown_mid = (steps != last_len_ff) ? hold_ticks_ff : countdown_ff;

      step_plus = LEN_W'(step_ff) + LEN_W'(1);
      if (tick_ff >= delay_in) begin
         step_in = (step_plus >= steps) ? '0 : step_plus[STEP_W-1:0];
         tick_in = '0;
      end else begin
         step_in = step_ff;
         tick_in = tick_ff + TICK_W'(1);
      end

      if (countdown_mid != '0) begin
         countdown_in = countdown_mid - HOLD_W'(1);
         shown        = steps[LED_W-1:0];
      end else begin
         countdown_in = countdown_mid;
         shown        = LED_W'(step_in);
      end

      stage_in.gate_level[0] = req_payload.gate_length_0;
      stage_in.gate_level[1] = req_payload.gate_length_1;
      stage_in.gate_level[2] = req_payload.gate_length_2;
      stage_in.gate_level[3] = req_payload.gate_length_3;
      stage_in.delay = delay_in;
      stage_in.tick  = tick_ff;
      if (primed_ff) begin
         stage_in.pattern_bits   = row_new;
         stage_in.current_step   = 5'(step_in);
         stage_in.showing_length = (countdown_mid != '0);
         for (int b = 0; b < LED_W; b++) begin
            stage_in.step_leds[b] = shown[LED_W-1-b];
         end
      end else begin
         // Priming tick: everything off, step as it stands
         stage_in.pattern_bits   = '0;
         stage_in.current_step   = 5'(step_ff);
         stage_in.showing_length = 1'b0;
         stage_in.step_leds      = '0;
      end
   end

   // Update sequencer state on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < MAX_STEPS; s++) begin
            pattern_ff[s] <= '0;
         end
         step_ff      <= '0;
         tick_ff      <= '0;
         delay_ff     <= '0;
         refresh_ff   <= '0;
         last_len_ff  <= LEN_W'(1);
         countdown_ff <= '0;
         primed_ff    <= 1'b0;
      end else if (accept) begin
         last_len_ff <= steps;
         primed_ff   <= 1'b1;
         if (primed_ff) begin
            pattern_ff[step_ff] <= row_new;
            step_ff      <= step_in;
            tick_ff      <= tick_in;
            delay_ff     <= delay_in;
            refresh_ff   <= refresh_in;
            countdown_ff <= countdown_in;
         end
      end
   end

   // Hold the stage payload for the lanes
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

endmodule

@@ rtl/fcgss_gate_lane.sv @@
module fcgss_gate_lane (
   input  logic [fcgss_pkg::LEVEL_W-1:0] level,
   input  logic [fcgss_pkg::TICK_W-1:0]  delay,
   input  logic [fcgss_pkg::TICK_W-1:0]  tick,
   input  logic                          pattern_bit,
   output logic                          gate
);
   import fcgss_pkg::*;

   logic [LEVEL_W+TICK_W-1:0] product;
   logic [TICK_W-1:0]         limit;

   // Gate stays on for the fraction level/4096 of the delay
   always_comb begin
      product = (LEVEL_W+TICK_W)'(level) * (LEVEL_W+TICK_W)'(delay);
      limit   = TICK_W'(product >> GATE_SHIFT);
      gate    = pattern_bit && (tick < limit);
   end

endmodule

@@ rtl/four_channel_gate_step_sequencer_unit.sv @@
// Channel   Direction  Handshake        Payload
// req_      in         valid / stall    fcgss_pkg::req_type, one loop tick
// rsp_      out        valid / stall    fcgss_pkg::rsp_type, one result per tick
// csr_      in         valid / ready    register index and write data
//
// One tick per clock while req_stall is low; a result passes through the stage register, then the output register.
// The tick stage updates the sequencer state on each transfer; the gate lanes then
// multiply and compare from the stage register into the output register.
// Synchronous reset clears the 32-row pattern store at once; no clearing pass.
// rsp_stall backs up through the two registers; req_stall rises only when both are full.
module four_channel_gate_step_sequencer_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  fcgss_pkg::req_type                req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output fcgss_pkg::rsp_type                rsp_payload,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [fcgss_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [fcgss_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import fcgss_pkg::*;

   logic                     stage_valid_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff, rsp_in;
   stage_type                stage;
   logic                     load_out;
   logic                     accept;
   logic [CHANNEL_COUNT-1:0] lane_gate;

   assign load_out  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = stage_valid_ff && !load_out;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   fcgss_tick_ctrl u_tick_ctrl (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .csr_ready   (csr_ready),
      .accept      (accept),
      .req_payload (req_payload),
      .stage_out   (stage)
   );

   for (genvar ch = 0; ch < CHANNEL_COUNT; ch++) begin : g_lane
      fcgss_gate_lane u_lane (
         .level       (stage.gate_level[ch]),
         .delay       (stage.delay),
         .tick        (stage.tick),
         .pattern_bit (stage.pattern_bits[ch]),
         .gate        (lane_gate[ch])
      );
   end

   // Merge the lane gates with the display fields
   always_comb begin
      rsp_in.gate_outputs   = 4'(lane_gate);
      rsp_in.step_leds      = stage.step_leds;
      rsp_in.current_step   = stage.current_step;
      rsp_in.showing_length = stage.showing_length;
   end

   // Advance the two pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            stage_valid_ff <= 1'b1;
         end else if (load_out) begin
            stage_valid_ff <= 1'b0;
         end
         if (load_out) begin
            rsp_valid_ff <= stage_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_out && stage_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

@@ rtl/fcgss_checker.sv @@
module fcgss_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input fcgss_pkg::rsp_type rsp_payload
);
   import fcgss_pkg::*;

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed or dropped");

   // Step LEDs mirror the step whenever the length is not on show
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.showing_length |->
         rsp_payload.step_leds[0] == rsp_payload.current_step[4] &&
         rsp_payload.step_leds[1] == rsp_payload.current_step[3] &&
         rsp_payload.step_leds[2] == rsp_payload.current_step[2] &&
         rsp_payload.step_leds[3] == rsp_payload.current_step[1] &&
         rsp_payload.step_leds[4] == rsp_payload.current_step[0])
      else $error("step LEDs do not match current step");

   // Pipeline comes out of reset empty
   assert property (@(posedge clock)
      $fell(reset) |-> !req_stall && !rsp_valid)
      else $error("pipeline not empty after reset");

endmodule

bind four_channel_gate_step_sequencer_unit fcgss_checker u_fcgss_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

@@ verif/fcgss_check_pkg.sv @@
package fcgss_check_pkg;

   import fcgss_pkg::*;

   localparam int PRODUCT_W   = LEVEL_W + TICK_W;
   localparam int PRINT_LIMIT = 40;

   class tick_scoreboard;

      // Register copies
      logic [HOLD_W-1:0]        hold_ticks;
      logic [TICK_W-1:0]        tempo_offset;

      // Sequencer state as the block keeps it
      logic [CHANNEL_COUNT-1:0] pattern_rows [MAX_STEPS];
      logic [STEP_W-1:0]        step_index;
      logic [TICK_W-1:0]        tick_count;
      logic [TICK_W-1:0]        step_delay;
      int unsigned              refresh_count;
      logic [LEN_W-1:0]         last_length;
      logic [HOLD_W-1:0]        display_left;
      bit                       primed;

      rsp_type                  pending_results [$];
      int                       mismatches;
      int                       compared;

      function void restart();
         hold_ticks    = HOLD_RESET;
         tempo_offset  = OFFSET_RESET;
         foreach (pattern_rows[i])
            pattern_rows[i] = '0;
         step_index    = '0;
         tick_count    = '0;
         step_delay    = '0;
         refresh_count = 0;
         last_length   = LEN_W'(1);
         display_left  = '0;
         primed        = 1'b0;
         pending_results.delete();
         mismatches    = 0;
         compared      = 0;
      endfunction

      // Mirror a register transfer; unknown indexes fall through
      function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         unique case (index)
            CSR_DISPLAY_HOLD: begin
               hold_ticks = data;
            end
            CSR_TEMPO_OFFSET: begin
               tempo_offset = data[TICK_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function int pending_count();
         return pending_results.size();
      endfunction

      // Advance the sequencer by one tick and queue the result it gives
      function void predict_tick(req_type t);
         logic [LEN_W-1:0]         steps;
         logic [LEVEL_W-1:0]       levels [CHANNEL_COUNT];
         logic [CHANNEL_COUNT-1:0] gates;
         logic [PRODUCT_W-1:0]     limit;
         logic [LEN_W-1:0]         next_step;
         logic [LED_W-1:0]         shown;
         rsp_type                  result;

         steps = LEN_W'(t.length_level >> LENGTH_SHIFT) + LEN_W'(1);
         if (steps > LEN_W'(MAX_STEPS))
            steps = LEN_W'(MAX_STEPS);
         result = '0;

         // First tick after reset only notes the step count
         if (!primed) begin
            last_length = steps;
            primed = 1'b1;
            result.current_step = step_index;
            pending_results.push_back(result);
            return;
         end

         // Latch the delay at the start of each refresh period, floor at zero
         if (refresh_count == 0)
            step_delay = (tempo_offset >= TICK_W'(t.tempo_level)) ?
                         tempo_offset - TICK_W'(t.tempo_level) : '0;
         refresh_count = (refresh_count + 1) % TEMPO_REFRESH;

         // Record, then gate each channel against its share of the delay
         levels = '{t.gate_length_0, t.gate_length_1, t.gate_length_2, t.gate_length_3};
         gates = '0;
         for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            if (t.record_buttons[ch])
               pattern_rows[step_index][ch] = ~t.clear_pressed;
            limit = (PRODUCT_W'(levels[ch]) * PRODUCT_W'(step_delay)) >> GATE_SHIFT;
            gates[ch] = pattern_rows[step_index][ch] && (PRODUCT_W'(tick_count) < limit);
         end

         if (steps != last_length) begin
            last_length = steps;
            display_left = hold_ticks;
         end

         // Advance the step once the tick count reaches the delay
         if (tick_count >= step_delay) begin
            next_step = LEN_W'(step_index) + LEN_W'(1);
            step_index = (next_step >= steps) ? '0 : STEP_W'(next_step);
            tick_count = '0;
         end else begin
            tick_count = tick_count + TICK_W'(1);
         end

         if (display_left != 0) begin
            display_left = display_left - HOLD_W'(1);
            shown = LED_W'(steps);
            result.showing_length = 1'b1;
         end else begin
            shown = step_index;
         end

         result.gate_outputs = gates;
         result.step_leds    = {shown[0], shown[1], shown[2], shown[3], shown[4]};
         result.current_step = step_index;
         pending_results.push_back(result);
      endfunction

      task report(string what);
         if (mismatches < PRINT_LIMIT)
            $display("MISMATCH: %s", what);
         mismatches++;
      endtask

      // Compare one result transfer with the oldest prediction
      task check_result(rsp_type got);
         rsp_type want;
         if (pending_results.size() == 0) begin
            report($sformatf("result %h arrived with no tick outstanding", got));
            return;
         end
         want = pending_results.pop_front();
         if (got.gate_outputs !== want.gate_outputs)
            report($sformatf("result %0d gate_outputs %b, predicted %b",
                             compared, got.gate_outputs, want.gate_outputs));
         if (got.step_leds !== want.step_leds)
            report($sformatf("result %0d step_leds %b, predicted %b",
                             compared, got.step_leds, want.step_leds));
         if (got.current_step !== want.current_step)
            report($sformatf("result %0d current_step %0d, predicted %0d",
                             compared, got.current_step, want.current_step));
         if (got.showing_length !== want.showing_length)
            report($sformatf("result %0d showing_length %b, predicted %b",
                             compared, got.showing_length, want.showing_length));
         compared++;
      endtask

   endclass

endpackage

@@ verif/four_channel_gate_step_sequencer_unit_tb.sv @@
module four_channel_gate_step_sequencer_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import fcgss_pkg::*;
   import fcgss_check_pkg::*;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int TOTAL_TICKS = 1600;
   localparam int LONG_HOLD   = 80;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata   = '0;

   tick_scoreboard         board = new;
   int                     tick_no = 0;
   int                     settings_used = 0;
   int                     cycles = 0;
   bit                     quiet = 1'b0;
   bit                     long_hold_request = 1'b0;
   logic [LEVEL_W-1:0]     latch_lo = '0;
   logic [LEVEL_W-1:0]     latch_hi = '1;
   logic [4:0]             length_bucket = '0;

   four_channel_gate_step_sequencer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up once the run has gone far beyond its slowest correct length
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, board.pending_count());
      $display("** four_channel_gate_step_sequencer_unit: FAILED **");
      $finish;
   end

   // Result side: check each transfer, then pick the next stall value
   initial begin
      int   run_left;
      int   hold_left;
      logic next_stall;
      run_left  = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_result(rsp_payload);
         if (hold_left > 0) begin
            hold_left--;
            next_stall = (hold_left != 0);
            if (hold_left == 0)
               long_hold_request = 1'b0;
         end else if (long_hold_request) begin
            hold_left = LONG_HOLD;
            next_stall = 1'b1;
         end else if (quiet) begin
            next_stall = 1'b0;
         end else if (run_left > 0) begin
            run_left--;
            next_stall = rsp_stall;
         end else if ($urandom_range(0, 3) == 0) begin
            run_left = $urandom_range(0, 12);
            next_stall = 1'b1;
         end else begin
            run_left = $urandom_range(0, 19);
            next_stall = 1'b0;
         end
         rsp_stall <= next_stall;
      end
   end

   function automatic req_type tick_of(logic clear, logic [3:0] buttons,
                                       logic [LEVEL_W-1:0] tempo, logic [LEVEL_W-1:0] length,
                                       logic [LEVEL_W-1:0] g0, logic [LEVEL_W-1:0] g1,
                                       logic [LEVEL_W-1:0] g2, logic [LEVEL_W-1:0] g3);
      req_type t;
      t.clear_pressed  = clear;
      t.record_buttons = buttons;
      t.tempo_level    = tempo;
      t.length_level   = length;
      t.gate_length_0  = g0;
      t.gate_length_1  = g1;
      t.gate_length_2  = g2;
      t.gate_length_3  = g3;
      return t;
   endfunction

   function automatic logic [LEVEL_W-1:0] random_level();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return LEVEL_W'($urandom);
      endcase
   endfunction

   // Random tick: sparse recording, a step count that moves now and then,
   // and a tempo drawn from the phase's range on refresh ticks
   function automatic req_type random_tick(int n);
      req_type t;
      t.clear_pressed  = ($urandom_range(0, 2) == 0);
      t.record_buttons = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'h0;
      if (n > 0 && (n - 1) % TEMPO_REFRESH == 0)
         t.tempo_level = LEVEL_W'($urandom_range(latch_lo, latch_hi));
      else
         t.tempo_level = LEVEL_W'($urandom);
      if ($urandom_range(0, 39) == 0)
         length_bucket = 5'($urandom);
      t.length_level  = {length_bucket, 7'($urandom)};
      t.gate_length_0 = random_level();
      t.gate_length_1 = random_level();
      t.gate_length_2 = random_level();
      t.gate_length_3 = random_level();
      return t;
   endfunction

   // Offer one tick, hold it until the transfer, then maybe leave a gap
   task automatic send_tick(input req_type t);
      req_valid   <= 1'b1;
      req_payload <= t;
      do
         @(posedge clock);
      while (req_stall);
      board.predict_tick(t);
      tick_no++;
      if (!quiet && !long_hold_request && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   task automatic run_ticks(input int upto);
      while (tick_no < upto)
         send_tick(random_tick(tick_no));
   endtask

   // Stop offering and drain every outstanding result
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_count() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      board.write_register(index, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      board.restart();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed ticks under the reset-time settings
      settings_used = 1;
      send_tick(tick_of(1'b1, 4'hF, 12'hFFF, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
      send_tick(tick_of(1'b0, 4'hF, 12'hFFF, 12'h000, 12'hFFF, 12'h000, 12'hFFF, 12'h001));
      send_tick(tick_of(1'b0, 4'h0, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
      send_tick(tick_of(1'b1, 4'hA, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
      send_tick(tick_of(1'b0, 4'h0, 12'h555, 12'h7FF, 12'h800, 12'h800, 12'h800, 12'h800));
      send_tick(tick_of(1'b1, 4'h5, 12'hAAA, 12'h07F, 12'h040, 12'h040, 12'h040, 12'h040));
      send_tick(tick_of(1'b0, 4'h2, 12'hFFF, 12'h080, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
      send_tick(tick_of(1'b0, 4'hF, 12'h000, 12'hF80, 12'h000, 12'h000, 12'h000, 12'h000));
      send_tick(tick_of(1'b1, 4'h0, 12'h123, 12'hF80, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
      send_tick(tick_of(1'b0, 4'h9, 12'hEDC, 12'h37F, 12'h7FF, 12'h001, 12'hFFE, 12'hC00));
      send_tick(tick_of(1'b0, 4'h6, 12'h3FF, 12'h37F, 12'h3FF, 12'hFFF, 12'hFFF, 12'h3FF));
      send_tick(tick_of(1'b1, 4'hF, 12'hFFF, 12'h000, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));

      // Shorten the length display and poke an unmapped index
      settle();
      write_csr(CSR_DISPLAY_HOLD, 16'($urandom_range(1, 300)));
      write_csr(CSR_INDEX_W'($urandom_range(2, 15)), 16'($urandom));
      settings_used++;
      run_ticks(TEMPO_REFRESH + 1);

      // Offset of 4096 with a high tempo: short delays, frequent step wrap
      settle();
      write_csr(CSR_TEMPO_OFFSET, 16'd4096);
      write_csr(CSR_DISPLAY_HOLD, 16'd0);
      settings_used++;
      latch_lo = 12'd4000;
      latch_hi = 12'd4095;
      long_hold_request = 1'b1;
      run_ticks(2 * TEMPO_REFRESH + 1);

      // Highest offset, junk in the unused data bits: long steps, fine gate lengths
      settle();
      write_csr(CSR_TEMPO_OFFSET, {3'($urandom), 13'h1FFF});
      write_csr(CSR_DISPLAY_HOLD, 16'($urandom_range(1, 2000)));
      settings_used++;
      latch_lo = 12'd0;
      latch_hi = 12'd4095;
      run_ticks(3 * TEMPO_REFRESH + 1);

      // Offset below the latched tempo: zero delay, step moves every tick
      settle();
      write_csr(CSR_TEMPO_OFFSET, 16'($urandom_range(0, 3999)));
      write_csr(CSR_DISPLAY_HOLD, 16'hFFFF);
      settings_used++;
      latch_lo = 12'd4000;
      latch_hi = 12'd4095;
      quiet = 1'b1;
      run_ticks(TOTAL_TICKS);

      settle();
      repeat (8) @(posedge clock);

      $display("Ran %0d ticks through %0d register settings, %0d results compared, %0d mismatches.",
               tick_no, settings_used, board.compared, board.mismatches);
      $display("Covered recording and clearing, gate lengths, step wrap, length display and a long output hold-off.");
      if (board.mismatches == 0)
         $display("** four_channel_gate_step_sequencer_unit: PASSED **");
      else
         $display("** four_channel_gate_step_sequencer_unit: FAILED **");
      $finish;
   end

endmodule
